FILE: hdl/i2c_master_bit_engine_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the I2C master bit engine
// Shorthand for clocked implications with a synchronous reset disable.
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_BIT_ENGINE_TOP_MACROS_SVH
`define I2C_MASTER_BIT_ENGINE_TOP_MACROS_SVH

// same-cycle implication
`define I2CMBE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define I2CMBE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hdl/i2cmbe_pkg.sv
// ----------------------------------------------------------------------------
// i2cmbe_pkg
// Shared types and codes for the I2C master bit engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package i2cmbe_pkg;

   // command codes carried in the kind field
   localparam logic [2:0] KIND_NONE  = 3'd0;
   localparam logic [2:0] KIND_START = 3'd1;
   localparam logic [2:0] KIND_STOP  = 3'd2;
   localparam logic [2:0] KIND_WRITE = 3'd3;
   localparam logic [2:0] KIND_READ  = 3'd4;
   localparam logic [2:0] KIND_WACK  = 3'd5;

   // register indexes on the CSR port
   localparam int unsigned CSR_IDX_W  = 1;
   localparam int unsigned CSR_DATA_W = 8;
   localparam logic [CSR_IDX_W-1:0] CSR_TICKS_PER_US = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_ACK_TIMEOUT  = 1'b1;

   // register reset values
   localparam logic [7:0] TICKS_PER_US_RESET = 8'd1;
   localparam logic [7:0] ACK_TIMEOUT_RESET  = 8'd250;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] tx_byte;
      logic       send_ack;
      logic       sda_in;
   } req_payload_type;

   typedef struct packed {
      logic       scl_level;
      logic       sda_level;
      logic       sda_driven;
      logic       busy_res;
      logic       done_res;
      logic [7:0] rx_byte;
      logic       ack_missing;
   } rsp_payload_type;

endpackage

FILE: hdl/i2cmbe_req_if.sv
// ----------------------------------------------------------------------------
// i2cmbe_req_if
// Tick/command channel into the bit engine: valid, ready and payload.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface i2cmbe_req_if;
   logic                        valid;
   logic                        ready;
   i2cmbe_pkg::req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

FILE: hdl/i2cmbe_rsp_if.sv
// ----------------------------------------------------------------------------
// i2cmbe_rsp_if
// Pin/status channel out of the bit engine: valid, ready and payload.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface i2cmbe_rsp_if;
   logic                        valid;
   logic                        ready;
   i2cmbe_pkg::rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

FILE: hdl/i2c_master_bit_engine_top.sv
// ----------------------------------------------------------------------------
// i2c_master_bit_engine_top
// I2C master bit engine: one tick per request beat, one pin/status beat back.
//
//   channel | dir | handshake       | payload
//   --------+-----+-----------------+--------------------------------------
//   req_bus | in  | valid / ready   | kind, tx_byte, send_ack, sda_in
//   rsp_bus | out | valid / ready   | scl, sda, drive, busy, done, rx, nack
//   csr_*   | in  | wr_en only      | index, 8-bit write data
//
// One request beat per cycle unless the response stalls; its response is
// in the output register in the cycle after acceptance. The sequencer step is a
// single combinational pass from the state registers to their next values.
// A stalled response holds the input off (req ready = output slot free or taken).
// Synchronous active-high reset; no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module i2c_master_bit_engine_top (
   input  logic                                 clock,
   input  logic                                 reset,
   i2cmbe_req_if.sink                           req_bus,
   i2cmbe_rsp_if.source                         rsp_bus,
   input  logic                                 csr_wr_en,
   input  logic [i2cmbe_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [i2cmbe_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import i2cmbe_pkg::*;

   typedef enum logic [3:0] {
      PH_IDLE, PH_ST_B, PH_ST_C, PH_SP_B, PH_SP_C,
      PH_W_BIT, PH_W_HIGH, PH_W_LOW, PH_R_LOW, PH_R_HIGH,
      PH_K_B, PH_K_C, PH_AK_B, PH_AK_P
   } phase_type;

   // bus delay lengths, as log2 of microseconds
   localparam logic [1:0] US_1 = 2'd0;
   localparam logic [1:0] US_2 = 2'd1;
   localparam logic [1:0] US_4 = 2'd2;

   // config registers
   logic [7:0]  ticks_ff;
   logic [7:0]  timeout_ff;

   // sequencer state
   phase_type   phase_ff,   phase_in;
   logic [11:0] delay_ff,   delay_in;
   logic [3:0]  bit_ff,     bit_in;
   logic [7:0]  shift_ff,   shift_in;
   logic [7:0]  poll_ff,    poll_in;
   logic        scl_out_ff, scl_out_in;
   logic        sda_out_ff, sda_out_in;
   logic        drive_ff,   drive_in;
   logic        ack_sel_ff, ack_sel_in;
   logic        fail_ff,    fail_in;
   logic [7:0]  rx_ff,      rx_in;
   logic        done_ff,    done_in;
   logic        rsp_valid_ff;

   logic        req_accept;
   logic        samp_sda;
   logic [8:0]  poll_next;

   // hold time in ticks minus one, zero when the product is zero
   function automatic logic [11:0] hold_ticks(input logic [7:0] tpu,
                                              input logic [1:0] us_log2);
      logic [11:0] t;
      begin
         t = {4'b0, tpu} << us_log2;
         hold_ticks = (t == 12'd0) ? 12'd0 : t - 12'd1;
      end
   endfunction

   // handshake: take a beat whenever the output slot is free or draining
   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign req_accept    = req_bus.valid && req_bus.ready;
   assign samp_sda      = req_bus.payload.sda_in;
   assign poll_next     = {1'b0, poll_ff} + 9'd1;

   // one sequencer step per tick
   always_comb begin
      phase_in   = phase_ff;
      delay_in   = delay_ff;
      bit_in     = bit_ff;
      shift_in   = shift_ff;
      poll_in    = poll_ff;
      scl_out_in = scl_out_ff;
      sda_out_in = sda_out_ff;
      drive_in   = drive_ff;
      ack_sel_in = ack_sel_ff;
      fail_in    = fail_ff;
      rx_in      = rx_ff;
      done_in    = 1'b0;

      if (phase_ff == PH_IDLE) begin
         // command entry, first step runs this tick
         case (req_bus.payload.kind)
            KIND_START: begin
               drive_in   = 1'b1;
               sda_out_in = 1'b1;
               scl_out_in = 1'b1;
               delay_in   = hold_ticks(ticks_ff, US_4);
               phase_in   = PH_ST_B;
            end
            KIND_STOP: begin
               drive_in   = 1'b1;
               scl_out_in = 1'b0;
               sda_out_in = 1'b0;
               delay_in   = hold_ticks(ticks_ff, US_4);
               phase_in   = PH_SP_B;
            end
            KIND_WRITE: begin
               // init plus first data bit
               drive_in   = 1'b1;
               scl_out_in = 1'b0;
               bit_in     = 4'd0;
               sda_out_in = req_bus.payload.tx_byte[7];
               shift_in   = {req_bus.payload.tx_byte[6:0], 1'b0};
               delay_in   = hold_ticks(ticks_ff, US_2);
               phase_in   = PH_W_HIGH;
            end
            KIND_READ: begin
               // init plus first clock-low half
               drive_in   = 1'b0;
               shift_in   = 8'd0;
               bit_in     = 4'd0;
               ack_sel_in = req_bus.payload.send_ack;
               scl_out_in = 1'b0;
               delay_in   = hold_ticks(ticks_ff, US_2);
               phase_in   = PH_R_HIGH;
            end
            KIND_WACK: begin
               fail_in    = 1'b0;
               poll_in    = 8'd0;
               drive_in   = 1'b0;
               sda_out_in = 1'b1;
               delay_in   = hold_ticks(ticks_ff, US_1);
               phase_in   = PH_AK_B;
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end else if (delay_ff != 12'd0) begin
         delay_in = delay_ff - 12'd1;
      end else begin
         case (phase_ff)
            PH_ST_B: begin
               sda_out_in = 1'b0;
               delay_in   = hold_ticks(ticks_ff, US_4);
               phase_in   = PH_ST_C;
            end
            PH_ST_C: begin
               scl_out_in = 1'b0;
               phase_in   = PH_IDLE;
               done_in    = 1'b1;
            end
            PH_SP_B: begin
               scl_out_in = 1'b1;
               sda_out_in = 1'b1;
               delay_in   = hold_ticks(ticks_ff, US_4);
               phase_in   = PH_SP_C;
            end
            PH_SP_C: begin
               phase_in = PH_IDLE;
               done_in  = 1'b1;
            end
            PH_W_BIT: begin
               if (bit_ff[3]) begin
                  phase_in = PH_IDLE;
                  done_in  = 1'b1;
               end else begin
                  sda_out_in = shift_ff[7];
                  shift_in   = {shift_ff[6:0], 1'b0};
                  delay_in   = hold_ticks(ticks_ff, US_2);
                  phase_in   = PH_W_HIGH;
               end
            end
            PH_W_HIGH: begin
               scl_out_in = 1'b1;
               delay_in   = hold_ticks(ticks_ff, US_2);
               phase_in   = PH_W_LOW;
            end
            PH_W_LOW: begin
               scl_out_in = 1'b0;
               bit_in     = bit_ff + 4'd1;
               delay_in   = hold_ticks(ticks_ff, US_2);
               phase_in   = PH_W_BIT;
            end
            PH_R_LOW: begin
               scl_out_in = 1'b0;
               if (bit_ff[3]) begin
                  // byte complete: latch it and start the ACK/NACK bit
                  rx_in      = shift_ff;
                  drive_in   = 1'b1;
                  sda_out_in = !ack_sel_ff;
                  delay_in   = hold_ticks(ticks_ff, US_2);
                  phase_in   = PH_K_B;
               end else begin
                  delay_in   = hold_ticks(ticks_ff, US_2);
                  phase_in   = PH_R_HIGH;
               end
            end
            PH_R_HIGH: begin
               scl_out_in = 1'b1;
               shift_in   = {shift_ff[6:0], samp_sda};
               bit_in     = bit_ff + 4'd1;
               delay_in   = hold_ticks(ticks_ff, US_1);
               phase_in   = PH_R_LOW;
            end
            PH_K_B: begin
               scl_out_in = 1'b1;
               delay_in   = hold_ticks(ticks_ff, US_2);
               phase_in   = PH_K_C;
            end
            PH_K_C: begin
               scl_out_in = 1'b0;
               phase_in   = PH_IDLE;
               done_in    = 1'b1;
            end
            PH_AK_B: begin
               scl_out_in = 1'b1;
               delay_in   = hold_ticks(ticks_ff, US_1);
               phase_in   = PH_AK_P;
            end
            PH_AK_P: begin
               if (!samp_sda) begin
                  scl_out_in = 1'b0;
                  phase_in   = PH_IDLE;
                  done_in    = 1'b1;
               end else if (poll_next > {1'b0, timeout_ff}) begin
                  // timeout: flag it and run the first stop step now
                  fail_in    = 1'b1;
                  drive_in   = 1'b1;
                  scl_out_in = 1'b0;
                  sda_out_in = 1'b0;
                  delay_in   = hold_ticks(ticks_ff, US_4);
                  phase_in   = PH_SP_B;
               end else begin
                  poll_in = poll_next[7:0];
               end
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end
   end

   // state, config and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         ticks_ff     <= TICKS_PER_US_RESET;
         timeout_ff   <= ACK_TIMEOUT_RESET;
         phase_ff     <= PH_IDLE;
         delay_ff     <= 12'd0;
         bit_ff       <= 4'd0;
         shift_ff     <= 8'd0;
         poll_ff      <= 8'd0;
         scl_out_ff   <= 1'b1;
         sda_out_ff   <= 1'b1;
         drive_ff     <= 1'b1;
         ack_sel_ff   <= 1'b0;
         fail_ff      <= 1'b0;
         rx_ff        <= 8'd0;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_TICKS_PER_US: ticks_ff   <= csr_wdata;
               CSR_ACK_TIMEOUT:  timeout_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (req_accept) begin
            phase_ff   <= phase_in;
            delay_ff   <= delay_in;
            bit_ff     <= bit_in;
            shift_ff   <= shift_in;
            poll_ff    <= poll_in;
            scl_out_ff <= scl_out_in;
            sda_out_ff <= sda_out_in;
            drive_ff   <= drive_in;
            ack_sel_ff <= ack_sel_in;
            fail_ff    <= fail_in;
            rx_ff      <= rx_in;
            done_ff    <= done_in;
         end
         if (req_accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // response beat straight from the registers
   assign rsp_bus.valid               = rsp_valid_ff;
   assign rsp_bus.payload.scl_level   = scl_out_ff;
   assign rsp_bus.payload.sda_level   = sda_out_ff;
   assign rsp_bus.payload.sda_driven  = drive_ff;
   assign rsp_bus.payload.busy_res    = (phase_ff != PH_IDLE);
   assign rsp_bus.payload.done_res    = done_ff;
   assign rsp_bus.payload.rx_byte     = rx_ff;
   assign rsp_bus.payload.ack_missing = fail_ff;

endmodule

FILE: hdl/i2cmbe_checker.sv
// ----------------------------------------------------------------------------
// i2cmbe_checker
// Port-level checks on the bit engine, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "i2c_master_bit_engine_top_macros.svh"

module i2cmbe_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input i2cmbe_pkg::rsp_payload_type rsp_payload
);
   import i2cmbe_pkg::*;

   // every accepted tick produces a response beat next cycle
   `I2CMBE_ASSERT_NEXT(a_rsp_follows, clock, reset, req_valid && req_ready, rsp_valid, "no response after accepted tick")

   // a waiting response blocks the input side
   `I2CMBE_ASSERT_NOW(a_no_overrun, clock, reset, rsp_valid && !rsp_ready, !req_ready, "input taken while response stalled")

   // done and busy never together
   `I2CMBE_ASSERT_NOW(a_done_idle, clock, reset, rsp_valid && rsp_payload.done_res, !rsp_payload.busy_res, "done reported while busy")

   // stalled beat holds its payload
   `I2CMBE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload), "stalled response changed")

endmodule

bind i2c_master_bit_engine_top i2cmbe_checker u_i2cmbe_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_bus.valid),
   .req_ready   (req_bus.ready),
   .rsp_valid   (rsp_bus.valid),
   .rsp_ready   (rsp_bus.ready),
   .rsp_payload (rsp_bus.payload)
);
